// ===== rtl/core/rfb_pkg.sv =====
// ---------------------------------------------------------------------------
// rfb_pkg
// Shared types, codes and helpers of the 1bpp rectangle fill engine.
// ---------------------------------------------------------------------------
package rfb_pkg;

    localparam int CW = 15;

    typedef logic signed [CW-1:0] coord_t;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_FILL   = 2'd0;
    localparam mode_t MODE_BORDER = 2'd1;
    localparam mode_t MODE_READ   = 2'd2;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_ACTIVE_WIDTH  = 2'd0;
    localparam reg_idx_t REG_ACTIVE_HEIGHT = 2'd1;

    typedef struct packed {
        logic       empty;
        logic [8:0] x0;
        logic [8:0] x1;
        logic [7:0] y0;
        logic [7:0] y1;
    } span_t;

    typedef struct packed {
        logic       valid;
        logic       is_read;
        logic       black;
        logic [7:0] mask;
    } store_ctl_t;

    // MSB-first pixel mask covering bit positions start..stop of one byte
    function automatic logic [7:0] byte_mask(input logic [2:0] start, input logic [2:0] stop);
        logic [7:0] m;
        m = (8'hFF >> start) & (8'hFF << (3'd7 - stop));
        return m;
    endfunction

endpackage

// ===== rtl/core/rfb_clip.sv =====
// ---------------------------------------------------------------------------
// rfb_clip
// Clips one rectangle to the active area; flags an empty span.
// ---------------------------------------------------------------------------
module rfb_clip
    import rfb_pkg::*;
(
    input  coord_t     bx,
    input  coord_t     by,
    input  coord_t     bw,
    input  coord_t     bh,
    input  logic [8:0] eff_width,
    input  logic [7:0] eff_height,
    output span_t      span
);

    coord_t xe;
    coord_t ye;
    coord_t w_s;
    coord_t h_s;
    coord_t x0s;
    coord_t y0s;
    coord_t x1s;
    coord_t y1s;

    always_comb
    begin
        xe  = bx + bw;
        ye  = by + bh;
        w_s = coord_t'({6'b0, eff_width});
        h_s = coord_t'({7'b0, eff_height});
        x0s = bx[CW-1] ? '0 : bx;
        y0s = by[CW-1] ? '0 : by;
        x1s = (xe > w_s) ? w_s : xe;
        y1s = (ye > h_s) ? h_s : ye;
        span.empty = (x0s >= x1s) || (y0s >= y1s);
        span.x0    = x0s[8:0];
        span.x1    = x1s[8:0];
        span.y0    = y0s[7:0];
        span.y1    = y1s[7:0];
    end

endmodule

// ===== rtl/core/rfb_scan.sv =====
// ---------------------------------------------------------------------------
// rfb_scan
// Walks a clipped span row by row, one framebuffer byte per cycle,
// issuing masked read-modify-write words to the store.
// ---------------------------------------------------------------------------
module rfb_scan
    import rfb_pkg::*;
#(
    parameter int AW = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  span_t         span,
    input  logic [6:0]    stride,
    input  logic          black,
    output store_ctl_t    op_ctl,
    output logic [AW-1:0] op_addr,
    output logic          last
);

    localparam int SW = AW + 15;

    logic          busy_reg;
    logic [7:0]    row_reg;
    logic [7:0]    ylast_reg;
    logic [5:0]    col_reg;
    logic [5:0]    bfirst_reg;
    logic [5:0]    blast_reg;
    logic [2:0]    lo_reg;
    logic [2:0]    hi_reg;
    logic          black_reg;
    logic [AW-1:0] row_base_reg;

    logic [8:0]    x1m;
    logic [14:0]   prod;
    logic [SW-1:0] prod_ext;
    logic [SW-1:0] addr_sum;
    logic [SW-1:0] base_inc;
    logic          col_last;
    logic          row_last;
    logic [2:0]    start;
    logic [2:0]    stop;

    assign x1m      = span.x1 - 9'd1;
    assign prod     = 15'(span.y0) * 15'(stride);
    assign prod_ext = SW'(prod);
    assign addr_sum = SW'(row_base_reg) + SW'(col_reg);
    assign base_inc = SW'(row_base_reg) + SW'(stride);
    assign col_last = (col_reg == blast_reg);
    assign row_last = (row_reg == ylast_reg);
    assign start    = (col_reg == bfirst_reg) ? lo_reg : 3'd0;
    assign stop     = col_last ? hi_reg : 3'd7;

    assign op_addr        = addr_sum[AW-1:0];
    assign op_ctl.valid   = busy_reg;
    assign op_ctl.is_read = 1'b0;
    assign op_ctl.black   = black_reg;
    assign op_ctl.mask    = byte_mask(start, stop);
    assign last           = busy_reg && col_last && row_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
        end
        else if (last)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg      <= span.y0;
            ylast_reg    <= span.y1 - 8'd1;
            bfirst_reg   <= span.x0[8:3];
            col_reg      <= span.x0[8:3];
            blast_reg    <= x1m[8:3];
            lo_reg       <= span.x0[2:0];
            hi_reg       <= x1m[2:0];
            black_reg    <= black;
            row_base_reg <= prod_ext[AW-1:0];
        end
        else if (busy_reg)
        begin
            if (col_last)
            begin
                col_reg      <= bfirst_reg;
                row_reg      <= row_reg + 8'd1;
                row_base_reg <= base_inc[AW-1:0];
            end
            else
            begin
                col_reg <= col_reg + 6'd1;
            end
        end
    end

endmodule

// ===== rtl/core/rfb_store.sv =====
// ---------------------------------------------------------------------------
// rfb_store
// Framebuffer memory with a registered read, masked read-modify-write
// stage with write forwarding, byte read-back and a clearing pass.
// ---------------------------------------------------------------------------
module rfb_store
    import rfb_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  store_ctl_t    ctl,
    input  logic [AW-1:0] addr,
    output logic [7:0]    rdata,
    output logic          rdata_valid,
    output logic          clearing
);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    mem_q;

    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    logic          m_valid_reg;
    logic          m_read_reg;
    logic          m_black_reg;
    logic [7:0]    m_mask_reg;
    logic [AW-1:0] m_addr_reg;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;

    logic [7:0]    cur;
    logic [7:0]    upd;
    logic          m_write;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    assign cur       = fwd_hit_reg ? fwd_data_reg : mem_q;
    assign upd       = m_black_reg ? (cur & ~m_mask_reg) : (cur | m_mask_reg);
    assign m_write   = m_valid_reg && !m_read_reg;
    assign mem_we    = clearing_reg || m_write;
    assign mem_waddr = clearing_reg ? clr_addr_reg : m_addr_reg;
    assign mem_wdata = clearing_reg ? 8'd0 : upd;

    assign rdata       = cur;
    assign rdata_valid = m_valid_reg && m_read_reg;
    assign clearing    = clearing_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            m_valid_reg <= ctl.valid;
            fwd_hit_reg <= ctl.valid && m_write && (addr == m_addr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        m_read_reg   <= ctl.is_read;
        m_black_reg  <= ctl.black;
        m_mask_reg   <= ctl.mask;
        m_addr_reg   <= addr;
        fwd_data_reg <= upd;
    end

endmodule

// ===== rtl/core/rect_fill_border_1bpp.sv =====
// ---------------------------------------------------------------------------
// rect_fill_border_1bpp
// 2D fill engine over an internal one-bit-per-pixel framebuffer.
// ---------------------------------------------------------------------------
// The engine handles one command at a time and paints one framebuffer byte per
// cycle through a masked read-modify-write on the single store port. A fill
// covers R clipped rows of B bytes each, R*B store words; a border runs up to
// four such bands back to back, each after its own setup state; a byte read
// passes through the read and read-wait states, or skips the wait for an
// address beyond the store. After reset the store is swept to zero, all
// ((MAX_WIDTH+7)/8)*MAX_HEIGHT bytes (4096 by default), during which
// in_stall stays high; configuration writes are taken at any time. The next
// command is taken while an earlier result still waits in the output register.
// ---------------------------------------------------------------------------
module rect_fill_border_1bpp
    import rfb_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_data,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  logic signed [11:0] left,
    input  logic signed [11:0] top,
    input  logic signed [11:0] rect_width,
    input  logic signed [11:0] rect_height,
    input  logic              paint_black,
    input  logic signed [11:0] band_thickness,
    input  logic [11:0]       byte_address,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        read_byte,
    output logic              was_read
);

    localparam int STRIDE_MAX = (MAX_WIDTH + 7) / 8;
    localparam int DEPTH      = STRIDE_MAX * MAX_HEIGHT;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [8:0] W_CAP = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);
    localparam logic [7:0] H_CAP = (MAX_HEIGHT > 255) ? 8'd255 : 8'(MAX_HEIGHT);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_RWAIT = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [8:0]         width_reg;
    logic [7:0]         height_reg;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [1:0]         band_reg;
    logic [1:0]         band_next;
    logic [7:0]         res_byte_reg;
    logic [7:0]         res_byte_next;
    logic               res_read_reg;
    logic               res_read_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         read_byte_reg;
    logic [7:0]         read_byte_next;
    logic               was_read_reg;
    logic               was_read_next;

    mode_t              cmd_mode;
    logic signed [11:0] cmd_x;
    logic signed [11:0] cmd_y;
    logic signed [11:0] cmd_w;
    logic signed [11:0] cmd_h;
    logic signed [11:0] cmd_t;
    logic               cmd_black;
    logic [11:0]        cmd_addr;

    logic               in_accept;
    logic [8:0]         eff_width;
    logic [7:0]         eff_height;
    logic [9:0]         width_round;
    logic [6:0]         stride;

    coord_t             cx;
    coord_t             cy;
    coord_t             cw;
    coord_t             ch;
    coord_t             ct;
    coord_t             bx;
    coord_t             by;
    coord_t             bw;
    coord_t             bh;
    span_t              span;
    logic               last_band;
    logic               scan_load;

    store_ctl_t         scan_ctl;
    logic [AW-1:0]      scan_addr;
    logic               scan_last;
    store_ctl_t         st_ctl;
    logic [AW-1:0]      st_addr;
    logic [AW+11:0]     rd_addr_ext;
    logic               addr_ok;
    logic [7:0]         st_rdata;
    logic               st_rdata_valid;
    logic               clearing;

    assign in_accept   = in_valid && !in_stall;
    assign in_stall    = (state_reg != ST_IDLE) || clearing;
    assign out_valid   = out_valid_reg;
    assign read_byte   = read_byte_reg;
    assign was_read    = was_read_reg;

    assign eff_width   = (width_reg > W_CAP) ? W_CAP : width_reg;
    assign eff_height  = (height_reg > H_CAP) ? H_CAP : height_reg;
    assign width_round = {1'b0, eff_width} + 10'd7;
    assign stride      = width_round[9:3];

    assign cx = coord_t'(cmd_x);
    assign cy = coord_t'(cmd_y);
    assign cw = coord_t'(cmd_w);
    assign ch = coord_t'(cmd_h);
    assign ct = coord_t'(cmd_t);

    // band geometry: fill is one band, border is top, bottom, left, right
    always_comb
    begin
        bx = cx;
        by = cy;
        bw = cw;
        bh = ch;
        if (cmd_mode != MODE_FILL)
        begin
            case (band_reg)
                2'd0:
                begin
                    bh = ct;
                end
                2'd1:
                begin
                    by = cy + ch - ct;
                    bh = ct;
                end
                2'd2:
                begin
                    bw = ct;
                end
                default:
                begin
                    bx = cx + cw - ct;
                    bw = ct;
                end
            endcase
        end
    end

    assign last_band = (cmd_mode == MODE_FILL) || (band_reg == 2'd3);

    rfb_clip u_clip (
        .bx         (bx),
        .by         (by),
        .bw         (bw),
        .bh         (bh),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .span       (span)
    );

    rfb_scan #(
        .AW (AW)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (scan_load),
        .span    (span),
        .stride  (stride),
        .black   (cmd_black || (cmd_mode == MODE_BORDER)),
        .op_ctl  (scan_ctl),
        .op_addr (scan_addr),
        .last    (scan_last)
    );

    assign rd_addr_ext = (AW + 12)'(cmd_addr);
    assign addr_ok     = (32'(cmd_addr) < 32'(DEPTH));

    always_comb
    begin
        st_ctl  = scan_ctl;
        st_addr = scan_addr;
        if (state_reg == ST_READ)
        begin
            st_ctl.valid   = addr_ok;
            st_ctl.is_read = 1'b1;
            st_ctl.black   = 1'b0;
            st_ctl.mask    = 8'd0;
            st_addr        = rd_addr_ext[AW-1:0];
        end
    end

    rfb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (st_ctl),
        .addr        (st_addr),
        .rdata       (st_rdata),
        .rdata_valid (st_rdata_valid),
        .clearing    (clearing)
    );

    always_comb
    begin
        state_next     = state_reg;
        band_next      = band_reg;
        res_byte_next  = res_byte_reg;
        res_read_next  = res_read_reg;
        out_valid_next = out_valid_reg && out_stall;
        read_byte_next = read_byte_reg;
        was_read_next  = was_read_reg;
        scan_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    band_next     = 2'd0;
                    res_byte_next = 8'd0;
                    res_read_next = 1'b0;
                    case (mode) inside
                        MODE_FILL, MODE_BORDER: state_next = ST_SETUP;
                        MODE_READ:              state_next = ST_READ;
                        default:                state_next = ST_DONE;
                    endcase
                end
            end
            ST_SETUP:
            begin
                if (span.empty)
                begin
                    if (last_band)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        band_next = band_reg + 2'd1;
                    end
                end
                else
                begin
                    scan_load  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    if (last_band)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        band_next  = band_reg + 2'd1;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_READ:
            begin
                res_read_next = 1'b1;
                state_next    = addr_ok ? ST_RWAIT : ST_DONE;
            end
            ST_RWAIT:
            begin
                res_byte_next = st_rdata;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    read_byte_next = res_byte_reg;
                    was_read_next  = res_read_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            band_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            width_reg     <= 9'd256;
            height_reg    <= 8'd128;
        end
        else
        begin
            state_reg     <= state_next;
            band_reg      <= band_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (cfg_index == REG_ACTIVE_WIDTH))
            begin
                width_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == REG_ACTIVE_HEIGHT))
            begin
                height_reg <= cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_byte_reg  <= res_byte_next;
        res_read_reg  <= res_read_next;
        read_byte_reg <= read_byte_next;
        was_read_reg  <= was_read_next;
        if (in_accept)
        begin
            cmd_mode  <= mode;
            cmd_x     <= left;
            cmd_y     <= top;
            cmd_w     <= rect_width;
            cmd_h     <= rect_height;
            cmd_t     <= band_thickness;
            cmd_black <= paint_black;
            cmd_addr  <= byte_address;
        end
    end

    a_scan_in_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
        scan_ctl.valid |-> state_reg == ST_SCAN)
        else $error("scan word outside scan state");

    a_rdata_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        st_rdata_valid |-> state_reg == ST_RWAIT)
        else $error("store read data outside read wait");

    a_no_op_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !st_ctl.valid && state_reg == ST_IDLE)
        else $error("store access during clearing pass");

    a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && state_next == ST_IDLE) |=> out_valid_reg)
        else $error("finished command produced no result word");

endmodule
